FILE: rtl/core/ordered_list_insert_erase_defines.svh
// Assertion macros for the ordered list insert/erase block.
// Used by the top level; no other dependencies.
`ifndef ORDERED_LIST_INSERT_ERASE_DEFINES_SVH
`define ORDERED_LIST_INSERT_ERASE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define OLIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define OLIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/olie_pkg.sv
// Shared types and constants for the ordered list insert/erase block.
// No dependencies.
package olie_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int POS_W        = 5;
  localparam int VAL_W        = 32;
  localparam int CNT_W        = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_ERASE  = 1'b1;

  typedef struct packed {
    logic exec;
  } ctl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_status_t;

endpackage

FILE: rtl/core/olie_ifs.sv
// Valid/ready channel interfaces for operation and result words.
// Depends on olie_pkg.
interface olie_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [olie_pkg::POS_W-1:0]  position;
  logic signed [olie_pkg::VAL_W-1:0] item_value;

  modport source (output valid, opcode, position, item_value, input ready);
  modport sink   (input valid, opcode, position, item_value, output ready);
endinterface

interface olie_out_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [olie_pkg::CNT_W-1:0] entry_count;

  modport source (output valid, ok, entry_count, input ready);
  modport sink   (input valid, ok, entry_count, output ready);
endinterface

FILE: rtl/core/ordered_list_insert_erase.sv
// Ordered list with insert/erase at a position: top level.
// The result word is valid in the cycle after the operation word is taken.
// Throughput: one word per cycle while out_ready is high; every cell shifts in parallel.
// Reset (rst_n low, synchronous) empties the list; entry contents are not cleared.
// Depends on olie_pkg, olie_ifs, olie_ctrl, olie_dp and the assertion macros.
`include "ordered_list_insert_erase_defines.svh"

module ordered_list_insert_erase #(
  parameter int CAPACITY = olie_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  olie_in_if.sink    in_if,
  olie_out_if.source out_if
);

  olie_pkg::ctl_cmd_t   cmd;
  olie_pkg::dp_status_t status;

  olie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  olie_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .opcode     (in_if.opcode),
    .position   (in_if.position),
    .item_value (in_if.item_value),
    .res_ok     (out_if.ok),
    .res_count  (out_if.entry_count),
    .status     (status)
  );

  `OLIE_ASSERT_NEXT(a_exec_gives_result, clk, rst_n, cmd.exec, out_if.valid,
                    "accepted word produced no result")
  `OLIE_ASSERT_NEXT(a_erase_empty_rejected, clk, rst_n,
                    cmd.exec && status.empty && (in_if.opcode == olie_pkg::OP_ERASE),
                    !out_if.ok, "erase on empty list accepted")
  `OLIE_ASSERT_NEXT(a_insert_full_rejected, clk, rst_n,
                    cmd.exec && status.full && (in_if.opcode == olie_pkg::OP_INSERT),
                    !out_if.ok, "insert into full list accepted")
  `OLIE_ASSERT_NEXT(a_insert_head_done, clk, rst_n,
                    cmd.exec && !status.full && (in_if.opcode == olie_pkg::OP_INSERT)
                    && (in_if.position == '0),
                    out_if.ok, "insert at head of non-full list rejected")
  `OLIE_ASSERT_IMP(a_not_full_and_empty, clk, rst_n, status.full, !status.empty,
                   "list both full and empty")

endmodule

FILE: rtl/core/olie_ctrl.sv
// Handshake controller: accepts operation words, holds the result word valid.
// Depends on olie_pkg.
module olie_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output olie_pkg::ctl_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_HOLD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready  = (state_r == ST_IDLE) || out_ready;
  assign out_valid = (state_r == ST_HOLD);
  assign cmd.exec  = in_valid && in_ready;

  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = cmd.exec ? ST_HOLD : ST_IDLE;
      ST_HOLD: state_nxt = (cmd.exec || !out_ready) ? ST_HOLD : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/olie_dp.sv
// Datapath: row of entry cells with parallel shift, fill count, result word.
// Depends on olie_pkg.
module olie_dp #(
  parameter int CAPACITY = olie_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  olie_pkg::ctl_cmd_t                cmd,
  input  logic                              opcode,
  input  logic [olie_pkg::POS_W-1:0]        position,
  input  logic signed [olie_pkg::VAL_W-1:0] item_value,
  output logic                              res_ok,
  output logic [olie_pkg::CNT_W-1:0]        res_count,
  output olie_pkg::dp_status_t              status
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > olie_pkg::POS_W) ? CW : olie_pkg::POS_W;

  logic signed [olie_pkg::VAL_W-1:0] entries_r [CAPACITY];
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic [CMPW-1:0] cnt_nxt_x;
  logic            is_ins;
  logic            op_ok;
  logic            do_op;

  assign pos_x  = CMPW'(position);
  assign cnt_x  = CMPW'(count_r);
  assign is_ins = (opcode == olie_pkg::OP_INSERT);

  assign status.full  = (count_r == CW'(CAPACITY));
  assign status.empty = (count_r == '0);

  assign op_ok = is_ins ? (!status.full && (pos_x <= cnt_x)) : (pos_x < cnt_x);
  assign do_op = cmd.exec && op_ok;

  always_comb begin
    count_nxt = count_r;
    if (do_op) begin
      count_nxt = is_ins ? count_r + CW'(1) : count_r - CW'(1);
    end
  end

  assign cnt_nxt_x = CMPW'(count_nxt);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (do_op) begin
        if (is_ins) begin
          if (CMPW'(i) == pos_x) begin
            entries_r[i] <= item_value;
          end else if (CMPW'(i) > pos_x) begin
            entries_r[i] <= entries_r[(i > 0) ? i - 1 : 0];
          end
        end else if (CMPW'(i) >= pos_x) begin
          entries_r[i] <= entries_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_ok    <= op_ok;
      res_count <= cnt_nxt_x[olie_pkg::CNT_W-1:0];
    end
  end

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for ordered_list_insert_erase: a directed table then random
// insert/erase words, checked against a shadow list kept in the bench.
// Depends on olie_pkg, olie_ifs and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int CAP    = 16;
  localparam int N_RAND = 1875;

  typedef struct packed {
    logic       ok;
    logic [4:0] cnt;
  } list_res_t;

  typedef struct {
    logic              op;
    logic [4:0]        pos;
    logic signed [31:0] val;
    bit                fixed;
    logic              ok;
    logic [4:0]        cnt;
  } dir_row_t;

  logic clk;
  logic rst_n;

  olie_in_if  in_if ();
  olie_out_if out_if ();

  ordered_list_insert_erase #(.CAPACITY(CAP)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  logic signed [31:0] shadow_list [CAP];
  int                 shadow_count;
  list_res_t          pending_results [$];

  bit        cur_fixed;
  list_res_t cur_fixed_res;
  bit        quiet;
  bit        hold_active;
  bit        hold_done;
  bit        grow_phase;

  int n_sent;
  int n_checked;
  int err_cnt;
  int n_ins;
  int n_ins_rej;
  int n_era;
  int n_era_rej;
  int n_full;
  int n_empty;

  dir_row_t dir_tab [27] = '{
    '{olie_pkg::OP_ERASE,  5'd0,  32'h0000_0000, 1'b1, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd1,  32'h0000_0005, 1'b1, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd16, 32'h1234_5678, 1'b1, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd0,  32'h7FFF_FFFF, 1'b1, 1'b1, 5'd1},
    '{olie_pkg::OP_INSERT, 5'd0,  32'h8000_0000, 1'b1, 1'b1, 5'd2},
    '{olie_pkg::OP_INSERT, 5'd2,  32'hFFFF_FFFF, 1'b1, 1'b1, 5'd3},
    '{olie_pkg::OP_INSERT, 5'd4,  32'h0000_0001, 1'b1, 1'b0, 5'd3},
    '{olie_pkg::OP_ERASE,  5'd3,  32'hFFFF_FFFF, 1'b1, 1'b0, 5'd3},
    '{olie_pkg::OP_ERASE,  5'd1,  32'h0000_0000, 1'b1, 1'b1, 5'd2},
    '{olie_pkg::OP_INSERT, 5'd0,  32'h0000_0000, 1'b0, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd2,  32'h5555_5555, 1'b0, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd1,  32'hAAAA_AAAA, 1'b0, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd5,  32'h0000_0001, 1'b0, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd3,  32'hFFFF_FFFE, 1'b0, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd0,  32'h8000_0001, 1'b0, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd8,  32'h7FFF_FFFE, 1'b0, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd4,  32'h0F0F_0F0F, 1'b0, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd10, 32'hF0F0_F0F0, 1'b0, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd6,  32'h0000_FFFF, 1'b0, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd12, 32'hFFFF_0000, 1'b0, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd1,  32'h0000_0100, 1'b0, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd14, 32'hDEAD_0001, 1'b0, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd15, 32'h0BAD_0002, 1'b0, 1'b0, 5'd0},
    '{olie_pkg::OP_INSERT, 5'd0,  32'h0000_0003, 1'b1, 1'b0, 5'd16},
    '{olie_pkg::OP_ERASE,  5'd16, 32'h0000_0000, 1'b1, 1'b0, 5'd16},
    '{olie_pkg::OP_ERASE,  5'd15, 32'h0000_0000, 1'b1, 1'b1, 5'd15},
    '{olie_pkg::OP_ERASE,  5'd0,  32'h0000_0000, 1'b0, 1'b0, 5'd0}
  };

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic list_res_t apply_list_op(input logic op, input logic [4:0] pos,
                                              input logic signed [31:0] val);
    list_res_t r;
    r.ok = 1'b0;
    if (op == olie_pkg::OP_INSERT) begin
      n_ins++;
      if (shadow_count < CAP && int'(pos) <= shadow_count) begin
        for (int i = shadow_count; i > int'(pos); i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[pos] = val;
        shadow_count++;
        r.ok = 1'b1;
        if (shadow_count == CAP) n_full++;
      end else begin
        n_ins_rej++;
      end
    end else begin
      n_era++;
      if (int'(pos) < shadow_count) begin
        for (int i = int'(pos) + 1; i < shadow_count; i++) shadow_list[i-1] = shadow_list[i];
        shadow_count--;
        r.ok = 1'b1;
        if (shadow_count == 0) n_empty++;
      end else begin
        n_era_rej++;
      end
    end
    r.cnt = shadow_count[4:0];
    return r;
  endfunction

  function automatic void note_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t mismatch: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    list_res_t r;
    list_res_t e;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        r = apply_list_op(in_if.opcode, in_if.position, in_if.item_value);
        pending_results.push_back(cur_fixed ? cur_fixed_res : r);
        n_sent++;
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result ok=%0b count=%0d",
                                  out_if.ok, out_if.entry_count));
        end else begin
          e = pending_results.pop_front();
          n_checked++;
          if (out_if.ok !== e.ok)
            note_mismatch($sformatf("ok: expected %0b, got %0b", e.ok, out_if.ok));
          if (out_if.entry_count !== e.cnt)
            note_mismatch($sformatf("entry_count: expected %0d, got %0d",
                                    e.cnt, out_if.entry_count));
        end
      end
    end
  end

  task automatic send_word(input logic op, input logic [4:0] pos,
                           input logic signed [31:0] val, input bit fixed,
                           input logic f_ok, input logic [4:0] f_cnt);
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.position   <= pos;
    in_if.item_value <= val;
    cur_fixed        = fixed;
    cur_fixed_res    = '{f_ok, f_cnt};
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic idle_in(input int cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic pick_word(output logic op, output logic [4:0] pos,
                           output logic signed [31:0] val);
    if ($urandom_range(0, 47) == 0) grow_phase = ~grow_phase;
    if (shadow_count == CAP && $urandom_range(0, 3) == 0) grow_phase = 1'b0;
    if (shadow_count == 0 && $urandom_range(0, 3) == 0) grow_phase = 1'b1;
    if ($urandom_range(0, 7) == 0) begin
      op  = 1'($urandom_range(0, 1));
      pos = 5'($urandom_range(0, 16));
    end else begin
      op = ($urandom_range(0, 99) < (grow_phase ? 75 : 25)) ? olie_pkg::OP_INSERT
                                                             : olie_pkg::OP_ERASE;
      if (op == olie_pkg::OP_INSERT) pos = 5'($urandom_range(0, shadow_count));
      else pos = (shadow_count == 0) ? 5'd0 : 5'($urandom_range(0, shadow_count - 1));
    end
    case ($urandom_range(0, 11))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7FFF_FFFF;
      2:       val = 32'hFFFF_FFFF;
      3:       val = 32'h0000_0000;
      default: val = $urandom;
    endcase
  endtask

  // result side: random stalls, one long hold-off once the input has run a while
  initial begin
    out_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && n_sent >= 600) begin
        hold_done   = 1'b1;
        hold_active = 1'b1;
        out_if.ready <= 1'b0;
        repeat (79) @(negedge clk);
        hold_active = 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic               op;
    logic [4:0]         pos;
    logic signed [31:0] val;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.opcode     = olie_pkg::OP_INSERT;
    in_if.position   = '0;
    in_if.item_value = '0;
    shadow_count     = 0;
    grow_phase       = 1'b1;
    for (int i = 0; i < CAP; i++) shadow_list[i] = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i])
      send_word(dir_tab[i].op, dir_tab[i].pos, dir_tab[i].val, dir_tab[i].fixed,
                dir_tab[i].ok, dir_tab[i].cnt);

    for (int n = 0; n < N_RAND; n++) begin
      quiet = (n >= N_RAND - 200);
      if (n == 1000) begin
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end else if (!quiet && !hold_active && $urandom_range(0, 9) == 0) begin
        idle_in($urandom_range(1, 19));
      end
      pick_word(op, pos, val);
      send_word(op, pos, val, 1'b0, 1'b0, 5'd0);
    end
    idle_in(1);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Ran %0d words: %0d inserts (%0d rejected), %0d erases (%0d rejected).",
             n_sent, n_ins, n_ins_rej, n_era, n_era_rej);
    $display("List filled %0d times, emptied %0d times; %0d results checked.",
             n_full, n_empty, n_checked);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
